// ----- sv/sird_pkg.sv -----
// Shared types and constants for the signed integer to radix digits converter.
// Holds the controller state encoding, the command and status bundles and the
// register indexes. No dependencies.
`default_nettype none

package sird_pkg;

  // Widths of the data path.
  localparam int unsigned DataW     = 32;  // input value
  localparam int unsigned CharW     = 8;   // one output symbol
  localparam int unsigned DigitW    = 4;   // one digit, radix up to 16
  localparam int unsigned RadixW    = 5;   // radix register
  localparam int unsigned SymTabW   = 64;  // one half of the symbol table
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned CntW      = 6;   // holds 0 .. MaxDigits

  // The long division consumes this many dividend bits per cycle.
  localparam int unsigned BitsPerStep   = 8;
  localparam int unsigned StepsPerDigit = DataW / BitsPerStep;
  localparam int unsigned StepCntW      = $clog2(StepsPerDigit);

  localparam logic [CharW-1:0]  MinusSymbol = 8'h2D;
  localparam logic [RadixW-1:0] RadixMin    = 5'd2;
  localparam logic [RadixW-1:0] RadixMax    = 5'd16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegRadix   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSymLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSymHigh = 2'd2;

  // Reset values of the registers.
  localparam logic [RadixW-1:0]  RadixRst  = 5'd10;
  localparam logic [SymTabW-1:0] SymLowRst = 64'h3736_3534_3332_3130;  // "01234567"
  localparam logic [SymTabW-1:0] SymHighRst = 64'h4645_4443_4241_3938; // "89ABCDEF"

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StSign,
    StDigits
  } sird_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new value
    logic div_step;   // run one slice of the long division
    logic div_push;   // this slice finishes a digit: push it
    logic out_sign;   // load the minus sign into the output register
    logic out_digit;  // load the top digit into the output register and pop it
  } sird_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic negative;    // the value being converted is negative
    logic quot_zero;   // the quotient of the current division slice is zero
    logic last_digit;  // one digit is left on the stack
    logic out_free;    // the output register can take a character this cycle
  } sird_stat_t;

endpackage

`default_nettype wire

// ----- sv/sird_ctrl.sv -----
// Controller of the radix converter: sequences load, division and output.
// Depends on sird_pkg.
`default_nettype none

module sird_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire sird_pkg::sird_stat_t stat_i,
  output sird_pkg::sird_cmd_t      cmd_o
);
  import sird_pkg::*;

  sird_state_e          state_q, state_d;
  logic [StepCntW-1:0]  step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = StDivide;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepCntW'(StepsPerDigit - 1)) begin
          cmd_o.div_push = 1'b1;
          if (stat_i.quot_zero) begin
            state_d = stat_i.negative ? StSign : StDigits;
          end
        end
      end
      StSign: begin
        if (stat_i.out_free) begin
          cmd_o.out_sign = 1'b1;
          state_d        = StDigits;
        end
      end
      StDigits: begin
        if (stat_i.out_free) begin
          cmd_o.out_digit = 1'b1;
          if (stat_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/sird_dpath.sv -----
// Datapath of the radix converter: configuration registers, slice-wise long
// division, digit stack and output register. Depends on sird_pkg.
`default_nettype none

module sird_dpath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [63:0]           cfg_data_i,
  input  wire logic [31:0]           s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,
  output logic                       m_axis_tlast,
  input  wire sird_pkg::sird_cmd_t   cmd_i,
  output sird_pkg::sird_stat_t       stat_o
);
  import sird_pkg::*;

  // Configuration.
  logic [RadixW-1:0]  radix_q;
  logic [SymTabW-1:0] sym_low_q, sym_high_q;
  logic [RadixW-1:0]  radix_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RadixRst;
      sym_low_q  <= SymLowRst;
      sym_high_q <= SymHighRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegRadix)   radix_q    <= cfg_data_i[RadixW-1:0];
      if (cfg_idx_i == RegSymLow)  sym_low_q  <= cfg_data_i;
      if (cfg_idx_i == RegSymHigh) sym_high_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (radix_q < RadixMin) begin
      radix_eff = RadixMin;
    end else if (radix_q > RadixMax) begin
      radix_eff = RadixMax;
    end else begin
      radix_eff = radix_q;
    end
  end

  // Long division. The work register starts as the magnitude and shifts left,
  // taking quotient bits in at the bottom; after a full pass it holds the
  // quotient and rem_d holds the digit, which is pushed while rem_q is cleared.
  logic [DataW-1:0]  work_q, work_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic              neg_q;
  logic [DigitW:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    trial  = '0;
    for (int i = 0; i < BitsPerStep; i++) begin
      trial  = {rem_d, work_d[DataW-1]};
      work_d = {work_d[DataW-2:0], 1'b0};
      if (trial >= radix_eff) begin
        trial     = trial - radix_eff;
        work_d[0] = 1'b1;
      end
      rem_d = trial[DigitW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q  <= s_axis_tdata[DataW-1];
      work_q <= s_axis_tdata[DataW-1] ? (DataW'(0) - s_axis_tdata) : s_axis_tdata;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= work_d;
      rem_q  <= cmd_i.div_push ? '0 : rem_d;
    end
  end

  // Digit stack: the least significant digit is pushed first, so pops come
  // out most significant first. Entry 0 is the top.
  logic [DigitW-1:0] stk_q [MaxDigits];
  logic [CntW-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_push) begin
      stk_q[0] <= rem_d;
      for (int i = 1; i < MaxDigits; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (cmd_i.out_digit) begin
      for (int i = 0; i < MaxDigits - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_push) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.out_digit) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Symbol lookup for the digit on top of the stack.
  logic [2*SymTabW-1:0] sym_tab;
  logic [CharW-1:0]     top_sym;

  assign sym_tab = {sym_high_q, sym_low_q};
  assign top_sym = sym_tab[{stk_q[0], 3'b000} +: CharW];

  // Output register.
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;
  logic             out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_sign || cmd_i.out_digit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_sign) begin
      out_char_q <= MinusSymbol;
      out_last_q <= 1'b0;
    end else if (cmd_i.out_digit) begin
      out_char_q <= top_sym;
      out_last_q <= (cnt_q == CntW'(1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  assign stat_o.negative   = neg_q;
  assign stat_o.quot_zero  = (work_d == '0);
  assign stat_o.last_digit = (cnt_q == CntW'(1));
  assign stat_o.out_free   = out_free;

endmodule

`default_nettype wire

// ----- sv/signed_integer_to_radix_digits.sv -----
// Top level of the signed integer to radix digits converter.
// Instantiates sird_ctrl and sird_dpath; depends on sird_pkg.
//
//   Channel   Direction  Payload (lowest bit first)      Per transfer
//   s_axis    in         tdata[31:0] value (signed)      one value
//   m_axis    out        tdata[7:0] character, tlast     one character
//   cfg       in         idx 0 radix, 1 low symbols,     one register write
//                        2 high symbols
//
// A value is loaded first. Each digit then costs four slices of long division,
// eight dividend bits per cycle against the radix, and each output character
// is loaded into the output register once that register is free.
// Reset restores radix 10 and the symbols "0123456789ABCDEF". A stall on the
// output side holds the converter in its output phase; the input is taken
// again only once the previous string has been handed to the output register.
`default_nettype none

module signed_integer_to_radix_digits (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] character
  output logic             m_axis_tlast    // last character of the string
);
  import sird_pkg::*;

  sird_cmd_t  cmd;
  sird_stat_t stat;

  // The controller walks through load, division slices, the optional sign and
  // the digit pops; it alone decides when a new value may be transferred in.
  sird_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // The datapath holds the registers, the divider, the digit stack and the
  // output register that separates the converter from the consumer.
  sird_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire
